### sv/rfd_pkg.sv
`default_nettype none

package rfd_pkg;

  localparam int unsigned FAIL_LIMIT = 10;
  localparam int unsigned FailCntW   = 4;

  localparam logic [7:0]  SYNC1_BYTE = 8'h55;
  localparam logic [7:0]  SYNC2_BYTE = 8'hAA;
  localparam logic [7:0]  MIN_LENGTH = 8'd4;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [7:0]  LAST_POS   = 8'hFF;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_PACKET_LENGTH = 2'd0;
  localparam logic [1:0] CFG_LENGTH_LIMIT      = 2'd1;
  localparam logic [1:0] CFG_SOURCE_ID         = 2'd2;

  localparam logic [7:0]  RST_MIN_PACKET_LENGTH = 8'd9;
  localparam logic [7:0]  RST_LENGTH_LIMIT      = 8'd29;
  localparam logic [15:0] RST_SOURCE_ID         = 16'd1;

  typedef enum logic [2:0] {
    V_OK        = 3'd0,
    V_SHORT     = 3'd1,
    V_BAD_SYNC1 = 3'd2,
    V_BAD_SYNC2 = 3'd3,
    V_BAD_LEN   = 3'd4,
    V_TRUNC     = 3'd5,
    V_BAD_SRC   = 3'd6,
    V_CRC_BAD   = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [7:0]  min_packet_length;
    logic [7:0]  length_limit;
    logic [15:0] source_id;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] byte_value;
    logic       last_byte;
  } stage_t;

  // crc16 modbus, one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/rfd_ifs.sv
`default_nettype none

interface rfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface rfd_verdict_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic [7:0] payload_length;
  logic [7:0] frame_type;
  logic [7:0] frame_state;
  logic [7:0] data_first;
  logic [7:0] data_second;
  logic [7:0] data_third;
  logic       fault_alarm;

  modport source (output valid, output verdict, output payload_length, output frame_type,
                  output frame_state, output data_first, output data_second,
                  output data_third, output fault_alarm, input ready);
  modport sink   (input valid, input verdict, input payload_length, input frame_type,
                  input frame_state, input data_first, input data_second,
                  input data_third, input fault_alarm, output ready);
endinterface

`default_nettype wire

### sv/radio_frame_deframer_crc16.sv
// Radio frame deframer with CRC16-Modbus check.
// byte_i carries one packet byte per request, last_byte set on the final byte of
// a packet. result_o carries one verdict per packet with the length, type, state
// and first three data bytes, plus a fault alarm after ten short, sync or crc
// failures with no good frame between them.
// Configuration is a plain write port: cfg_we_i, cfg_idx_i (0 min packet length,
// 1 length limit, 2 source id), cfg_wdata_i; write only while the block is idle.
// A byte goes into the input register, then the parser and its crc step update
// the packet state from it; the verdict goes into the result register when the
// parser takes the final byte. Throughput: one byte per cycle with a byte-wise
// crc update, as long as no final byte waits for a full result register.
// When the receiver stalls, the result register holds the verdict; data bytes keep
// flowing and only a further final byte waits for the result register to free.
// Reset clears packet state, the failure count and both valid flags, and loads
// the configuration defaults.
`default_nettype none

module radio_frame_deframer_crc16
  import rfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rfd_byte_if.sink         byte_i,
  rfd_verdict_if.source    result_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  rfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rfd_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  rfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .stage_i   (stage),
    .advance_o (advance),
    .result_o  (result_o)
  );

  // alarm only on the counted failure kinds
  a_alarm_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.fault_alarm) |->
      (result_o.verdict == V_SHORT || result_o.verdict == V_BAD_SYNC1 ||
       result_o.verdict == V_BAD_SYNC2 || result_o.verdict == V_CRC_BAD))
    else $error("fault alarm on a verdict that is not counted");

  // a good frame has a length byte in range
  a_ok_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.verdict == V_OK) |->
      (result_o.payload_length >= MIN_LENGTH &&
       result_o.payload_length <= cfg.length_limit))
    else $error("ok verdict with length out of range");

  // a length below four must be caught no later than the length check
  a_small_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.payload_length < MIN_LENGTH) |->
      (result_o.verdict == V_SHORT || result_o.verdict == V_BAD_SYNC1 ||
       result_o.verdict == V_BAD_SYNC2 || result_o.verdict == V_BAD_LEN))
    else $error("small length byte passed the length check");

endmodule

`default_nettype wire

### sv/rfd_cfg_regs.sv
`default_nettype none

module rfd_cfg_regs
  import rfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_PACKET_LENGTH: cfg_d.min_packet_length = cfg_wdata_i[7:0];
        CFG_LENGTH_LIMIT:      cfg_d.length_limit      = cfg_wdata_i[7:0];
        CFG_SOURCE_ID:         cfg_d.source_id         = cfg_wdata_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_packet_length <= RST_MIN_PACKET_LENGTH;
      cfg_q.length_limit      <= RST_LENGTH_LIMIT;
      cfg_q.source_id         <= RST_SOURCE_ID;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/rfd_in_reg.sv
`default_nettype none

module rfd_in_reg
  import rfd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rfd_byte_if.sink  byte_i,
  input  wire logic advance_i,
  output stage_t    stage_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  assign byte_i.ready = !valid_q || advance_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i.byte_value;
      last_q <= byte_i.last_byte;
    end
  end

  assign stage_o = '{valid: valid_q, byte_value: byte_q, last_byte: last_q};

endmodule

`default_nettype wire

### sv/rfd_parser.sv
`default_nettype none

module rfd_parser
  import rfd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  cfg_t        cfg_i,
  input  stage_t      stage_i,
  output logic        advance_o,
  rfd_verdict_if.source result_o
);

  logic [7:0]          pos_q, pos_d;
  logic [15:0]         crc_q, crc_d;
  logic [7:0]          len_q, len_d;
  logic [4:0][7:0]     fld_q, fld_d;
  logic [15:0]         rcrc_q, rcrc_d;
  logic [2:0]          ferr_q, ferr_d;
  logic [FailCntW-1:0] fail_q, fail_d;

  logic                out_valid_q;
  verdict_e            verdict_d;
  logic                alarm_d;
  logic [7:0]          out_len_q, out_type_q, out_state_q;
  logic [7:0]          out_d1_q, out_d2_q, out_d3_q;
  logic [2:0]          out_verdict_q;
  logic                out_alarm_q;

  logic                fire, emit;
  logic [8:0]          pay_end;
  logic [7:0]          b;
  logic [FailCntW-1:0] fail_inc;

  assign advance_o = !stage_i.last_byte || !out_valid_q || result_o.ready;
  assign fire      = stage_i.valid && advance_o;
  assign emit      = fire && stage_i.last_byte;
  assign b         = stage_i.byte_value;
  assign pay_end   = {1'b0, len_q} + 9'd2;
  assign fail_inc  = fail_q + FailCntW'(1);

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    len_d     = len_q;
    fld_d     = fld_q;
    rcrc_d    = rcrc_q;
    ferr_d    = ferr_q;
    fail_d    = fail_q;
    verdict_d = V_OK;
    alarm_d   = 1'b0;

    if (fire && pos_q != LAST_POS) begin
      pos_d = pos_q + 8'd1;
      if (pos_q == 8'd0) begin
        if (b != SYNC1_BYTE && ferr_q == V_OK) ferr_d = V_BAD_SYNC1;
      end else if (pos_q == 8'd1) begin
        if (b != SYNC2_BYTE && ferr_q == V_OK) ferr_d = V_BAD_SYNC2;
      end else if (pos_q == 8'd2) begin
        len_d = b;
        if ((b < MIN_LENGTH || b > cfg_i.length_limit) && ferr_q == V_OK) ferr_d = V_BAD_LEN;
        crc_d = crc16_byte(crc_q, b);
      end else if ({1'b0, pos_q} <= pay_end) begin
        crc_d = crc16_byte(crc_q, b);
        if (pos_q == 8'd3) begin
          if (b != cfg_i.source_id[15:8] && ferr_q == V_OK) ferr_d = V_BAD_SRC;
        end else if (pos_q == 8'd4) begin
          if (b != cfg_i.source_id[7:0] && ferr_q == V_OK) ferr_d = V_BAD_SRC;
        end else if (pos_q <= 8'd9) begin
          fld_d[3'(pos_q - 8'd5)] = b;
        end
      end else if ({1'b0, pos_q} == pay_end + 9'd1) begin
        rcrc_d = {b, 8'h00};
      end else if ({1'b0, pos_q} == pay_end + 9'd2) begin
        rcrc_d = rcrc_q | {8'h00, b};
      end
    end

    // verdict from the state after this byte
    if (pos_d < cfg_i.min_packet_length) begin
      verdict_d = V_SHORT;
    end else if (ferr_d == V_BAD_SYNC1 || ferr_d == V_BAD_SYNC2 || ferr_d == V_BAD_LEN) begin
      verdict_d = verdict_e'(ferr_d);
    end else if (pos_d < 8'd2) begin
      verdict_d = V_BAD_SYNC2;
    end else if (pos_d < 8'd3) begin
      verdict_d = V_BAD_LEN;
    end else if ({1'b0, pos_d} < {1'b0, len_d} + 9'd5) begin
      verdict_d = V_TRUNC;
    end else if (ferr_d == V_BAD_SRC) begin
      verdict_d = V_BAD_SRC;
    end else if (crc_d != rcrc_d) begin
      verdict_d = V_CRC_BAD;
    end else begin
      verdict_d = V_OK;
    end

    if (emit) begin
      case (verdict_d) inside
        V_OK: fail_d = '0;
        V_SHORT, V_BAD_SYNC1, V_BAD_SYNC2, V_CRC_BAD: begin
          if (fail_inc >= FailCntW'(FAIL_LIMIT)) begin
            alarm_d = 1'b1;
            fail_d  = '0;
          end else begin
            fail_d = fail_inc;
          end
        end
        default: fail_d = fail_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= CRC_INIT;
      len_q  <= '0;
      fld_q  <= '0;
      rcrc_q <= '0;
      ferr_q <= '0;
      fail_q <= '0;
    end else begin
      fail_q <= fail_d;
      if (emit) begin
        pos_q  <= '0;
        crc_q  <= CRC_INIT;
        len_q  <= '0;
        fld_q  <= '0;
        rcrc_q <= '0;
        ferr_q <= '0;
      end else begin
        pos_q  <= pos_d;
        crc_q  <= crc_d;
        len_q  <= len_d;
        fld_q  <= fld_d;
        rcrc_q <= rcrc_d;
        ferr_q <= ferr_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_verdict_q <= verdict_d;
      out_len_q     <= len_d;
      out_type_q    <= fld_d[0];
      out_state_q   <= fld_d[1];
      out_d1_q      <= fld_d[2];
      out_d2_q      <= fld_d[3];
      out_d3_q      <= fld_d[4];
      out_alarm_q   <= alarm_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.verdict        = out_verdict_q;
  assign result_o.payload_length = out_len_q;
  assign result_o.frame_type     = out_type_q;
  assign result_o.frame_state    = out_state_q;
  assign result_o.data_first     = out_d1_q;
  assign result_o.data_second    = out_d2_q;
  assign result_o.data_third     = out_d3_q;
  assign result_o.fault_alarm    = out_alarm_q;

endmodule

`default_nettype wire

### tb/sv/radio_frame_deframer_crc16_tb.sv
module radio_frame_deframer_crc16_tb;
  import rfd_pkg::*;

  localparam logic [1:0]  CFG_SPARE     = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned SHOW_LIMIT    = 10;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_e;

  typedef struct packed {
    verdict_e   verdict;
    logic [7:0] payload_length;
    logic [7:0] frame_type;
    logic [7:0] frame_state;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [7:0] data_third;
    logic       fault_alarm;
  } frame_report_t;

  class verdict_board;
    logic [7:0]    min_len;
    logic [7:0]    len_limit;
    logic [15:0]   src_id;
    logic [7:0]    pos_cnt;
    logic [15:0]   crc_acc;
    logic [7:0]    len_byte;
    logic [7:0]    hdr_fields [5];
    logic [15:0]   crc_rx;
    verdict_e      first_fault;
    logic [3:0]    fail_run;
    frame_report_t pending_reports[$];
    int            errors;
    int            shown;

    function new();
      min_len   = RST_MIN_PACKET_LENGTH;
      len_limit = RST_LENGTH_LIMIT;
      src_id    = RST_SOURCE_ID;
      fail_run  = '0;
      errors    = 0;
      shown     = 0;
      clear_frame();
    endfunction

    // reflected crc16, lsb first
    static function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
      return r;
    endfunction

    function void clear_frame();
      pos_cnt  = '0;
      crc_acc  = CRC_INIT;
      len_byte = '0;
      foreach (hdr_fields[i]) hdr_fields[i] = '0;
      crc_rx      = '0;
      first_fault = V_OK;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [15:0] data);
      case (idx)
        CFG_MIN_PACKET_LENGTH: min_len = data[7:0];
        CFG_LENGTH_LIMIT:      len_limit = data[7:0];
        CFG_SOURCE_ID:         src_id = data;
        default: ;
      endcase
    endfunction

    function void flag(input verdict_e v);
      if (first_fault == V_OK) first_fault = v;
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      int            p;
      int            pay_end;
      int            cnt;
      verdict_e      v;
      frame_report_t r;
      p       = int'(pos_cnt);
      pay_end = int'(len_byte) + 2;
      // bytes past index 254 are dropped
      if (p < 255) begin
        pos_cnt = pos_cnt + 8'd1;
        if (p == 0) begin
          if (b != SYNC1_BYTE) flag(V_BAD_SYNC1);
        end else if (p == 1) begin
          if (b != SYNC2_BYTE) flag(V_BAD_SYNC2);
        end else if (p == 2) begin
          len_byte = b;
          if (b < MIN_LENGTH || b > len_limit) flag(V_BAD_LEN);
          crc_acc = crc_step(crc_acc, b);
        end else if (p <= pay_end) begin
          crc_acc = crc_step(crc_acc, b);
          if (p == 3) begin
            if (b != src_id[15:8]) flag(V_BAD_SRC);
          end else if (p == 4) begin
            if (b != src_id[7:0]) flag(V_BAD_SRC);
          end else if (p <= 9) begin
            hdr_fields[p-5] = b;
          end
        end else if (p == pay_end + 1) begin
          crc_rx = {b, 8'h00};
        end else if (p == pay_end + 2) begin
          crc_rx[7:0] = b;
        end
      end
      if (!last) return;

      cnt = int'(pos_cnt);
      if (cnt < int'(min_len)) v = V_SHORT;
      else if (first_fault inside {V_BAD_SYNC1, V_BAD_SYNC2, V_BAD_LEN}) v = first_fault;
      else if (cnt < 2) v = V_BAD_SYNC2;
      else if (cnt < 3) v = V_BAD_LEN;
      else if (cnt < int'(len_byte) + 5) v = V_TRUNC;
      else if (first_fault == V_BAD_SRC) v = V_BAD_SRC;
      else if (crc_acc != crc_rx) v = V_CRC_BAD;
      else v = V_OK;

      r.fault_alarm = 1'b0;
      if (v == V_OK) begin
        fail_run = '0;
      end else if (v inside {V_SHORT, V_BAD_SYNC1, V_BAD_SYNC2, V_CRC_BAD}) begin
        fail_run = fail_run + 4'd1;
        if (fail_run >= FAIL_LIMIT) begin
          r.fault_alarm = 1'b1;
          fail_run      = '0;
        end
      end
      r.verdict        = v;
      r.payload_length = len_byte;
      r.frame_type     = hdr_fields[0];
      r.frame_state    = hdr_fields[1];
      r.data_first     = hdr_fields[2];
      r.data_second    = hdr_fields[3];
      r.data_third     = hdr_fields[4];
      pending_reports.push_back(r);
      clear_frame();
    endfunction

    function void check_report(input frame_report_t got);
      frame_report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("verdict %0d len %0d arrived with nothing pending",
                   got.verdict, got.payload_length);
        end
        return;
      end
      want = pending_reports.pop_front();
      if (got !== want) begin
        errors++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("mismatch want: v=%0d len=%0d type=%0d state=%0d d=%0d/%0d/%0d alarm=%0d",
                   want.verdict, want.payload_length, want.frame_type, want.frame_state,
                   want.data_first, want.data_second, want.data_third, want.fault_alarm);
          $display("         got:  v=%0d len=%0d type=%0d state=%0d d=%0d/%0d/%0d alarm=%0d",
                   got.verdict, got.payload_length, got.frame_type, got.frame_state,
                   got.data_first, got.data_second, got.data_third, got.fault_alarm);
        end
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  rfd_byte_if    byte_if ();
  rfd_verdict_if res_if ();

  radio_frame_deframer_crc16 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  verdict_board sb;
  int           hold_left  = 0;
  int           burst_left = 0;
  int           bytes_sent = 0;
  int unsigned  cycle_cnt  = 0;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("radio_frame_deframer_crc16_tb: done, errors");
      $finish;
    end
  end

  // result side: stall pattern of its own plus one long hold-off
  initial begin
    stall_mode_e mode;
    int          span;
    mode = STALL_NONE;
    span = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          span = $urandom_range(20, 80);
        end
        span--;
        case (mode)
          STALL_NONE:  res_if.ready <= 1'b1;
          STALL_LIGHT: res_if.ready <= ($urandom_range(0, 3) != 0);
          STALL_HEAVY: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:     res_if.ready <= span[2];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    frame_report_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.verdict        = verdict_e'(res_if.verdict);
      got.payload_length = res_if.payload_length;
      got.frame_type     = res_if.frame_type;
      got.frame_state    = res_if.frame_state;
      got.data_first     = res_if.data_first;
      got.data_second    = res_if.data_second;
      got.data_third     = res_if.data_third;
      got.fault_alarm    = res_if.fault_alarm;
      sb.check_report(got);
    end
  end

  function automatic byte_q_t make_frame(input int len, input logic [15:0] src);
    byte_q_t     f;
    logic [15:0] c;
    f.push_back(SYNC1_BYTE);
    f.push_back(SYNC2_BYTE);
    f.push_back(len[7:0]);
    f.push_back(src[15:8]);
    f.push_back(src[7:0]);
    // type, state and data
    for (int i = 0; i < len - 2; i++) f.push_back(8'($urandom_range(0, 255)));
    c = CRC_INIT;
    for (int i = 2; i < f.size(); i++) c = verdict_board::crc_step(c, f[i]);
    f.push_back(c[15:8]);
    f.push_back(c[7:0]);
    return f;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    byte_if.valid      <= 1'b1;
    byte_if.byte_value <= b;
    byte_if.last_byte  <= last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    sb.note_byte(b, last);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) push_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // stop offering and wait until every verdict is back
  task automatic drain();
    byte_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic set_config(input logic [7:0] min_len, input logic [7:0] lim,
                            input logic [15:0] src);
    logic [7:0] junk_a;
    logic [7:0] junk_b;
    // upper bits of the 8-bit registers must be dropped
    junk_a = 8'($urandom_range(0, 255));
    junk_b = 8'($urandom_range(0, 255));
    write_reg(CFG_MIN_PACKET_LENGTH, {junk_a, min_len});
    write_reg(CFG_LENGTH_LIMIT, {junk_b, lim});
    write_reg(CFG_SOURCE_ID, src);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  // well-formed frames, some broken in one place, cut short or padded, some plain noise
  task automatic random_packet();
    byte_q_t    pkt;
    int         hi;
    int         kind;
    int         at;
    int         n;
    logic [7:0] m;
    hi = (sb.len_limit >= MIN_LENGTH) ? int'(sb.len_limit) : 12;
    if (hi > 14 && $urandom_range(0, 7) != 0) hi = 14;
    if (hi > 40) hi = 40;
    pkt  = make_frame($urandom_range(4, hi), sb.src_id);
    kind = $urandom_range(0, 99);
    m    = 8'($urandom_range(1, 255));
    if (kind < 45) begin
      // keep it intact
    end else if (kind < 50) begin
      pkt[0] = pkt[0] ^ m;
    end else if (kind < 55) begin
      pkt[1] = pkt[1] ^ m;
    end else if (kind < 60) begin
      pkt[2] = 8'($urandom_range(0, 255));
    end else if (kind < 67) begin
      n = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > n) void'(pkt.pop_back());
    end else if (kind < 72) begin
      at = $urandom_range(3, 4);
      pkt[at] = pkt[at] ^ m;
    end else if (kind < 79) begin
      at = pkt.size() - 1 - $urandom_range(0, 1);
      pkt[at] = pkt[at] ^ m;
    end else if (kind < 86) begin
      repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 93) begin
      at = $urandom_range(5, pkt.size() - 3);
      pkt[at] = pkt[at] ^ m;
    end else begin
      pkt.delete();
      repeat ($urandom_range(1, 15)) pkt.push_back(8'($urandom_range(0, 255)));
    end
    send_packet(pkt);
  endtask

  task automatic random_run(input int n);
    int stop_at;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) random_packet();
  endtask

  initial begin
    byte_q_t pkt;
    sb = new();
    rst_ni             <= 1'b0;
    byte_if.valid      <= 1'b0;
    byte_if.byte_value <= '0;
    byte_if.last_byte  <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_MIN_PACKET_LENGTH;
    cfg_wdata_i        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: good frame under reset settings, then the missing header cases and a bad source id
    send_packet(make_frame(4, RST_SOURCE_ID));
    drain();
    set_config(8'd0, RST_LENGTH_LIMIT, RST_SOURCE_ID);
    pkt = '{8'h00};
    send_packet(pkt);
    pkt = '{SYNC1_BYTE};
    send_packet(pkt);
    pkt = '{SYNC1_BYTE, SYNC2_BYTE};
    send_packet(pkt);
    pkt = '{SYNC1_BYTE, SYNC2_BYTE, MIN_LENGTH};
    send_packet(pkt);
    pkt = make_frame(4, RST_SOURCE_ID);
    pkt[3] = pkt[3] ^ 8'h80;
    send_packet(pkt);

    drain();
    set_config(RST_MIN_PACKET_LENGTH, RST_LENGTH_LIMIT, RST_SOURCE_ID);
    random_run(30);
    // run of short packets to reach the alarm
    repeat (12) begin
      pkt = '{8'($urandom_range(0, 255))};
      send_packet(pkt);
    end

    drain();
    write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
    set_config(8'd0, 8'd255, 16'h0000);
    random_run(25);

    drain();
    set_config(8'd255, MIN_LENGTH, 16'hFFFF);
    random_run(12);

    // length limit below four: every length byte is rejected
    drain();
    set_config(8'($urandom_range(0, 9)), 8'd2, 16'($urandom_range(0, 65535)));
    random_run(12);

    drain();
    set_config(8'($urandom_range(0, 14)), 8'($urandom_range(4, 40)),
               16'($urandom_range(0, 65535)));
    hold_left = HOLD_CYCLES;
    random_run(45);

    // a frame that runs past the position counter
    drain();
    set_config(8'd0, 8'd255, 16'($urandom_range(0, 65535)));
    send_packet(make_frame(251, sb.src_id));
    random_run(8);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("radio_frame_deframer_crc16_tb: done, clean");
    end else begin
      $display("radio_frame_deframer_crc16_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
sv/rfd_pkg.sv
sv/rfd_ifs.sv
sv/rfd_cfg_regs.sv
sv/rfd_in_reg.sv
sv/rfd_parser.sv
sv/radio_frame_deframer_crc16.sv
tb/sv/radio_frame_deframer_crc16_tb.sv
